// ===== design/dstt_pkg.sv =====
// ----------------------------------------------------------------------------
// dstt_pkg
// Shared types and constants of the debounced speed trap timer.
// ----------------------------------------------------------------------------
`default_nettype none

package dstt_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_DISTANCE  = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED = 3'd4;

  // Divider geometry: distance_mm * 360 fits in 21 bits
  localparam int DIVIDEND_W = 21;
  localparam int DIVISOR_W  = 16;
  localparam int STEP_CNT_W = 5;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] timeout_ms;
    logic [11:0] distance_mm;
    logic [15:0] min_speed_centi;
    logic [15:0] max_speed_centi;
  } dstt_cfg_t;

  // One debouncer's state
  typedef struct packed {
    logic       last_raw;
    logic       stable;
    logic [7:0] ticks;
  } deb_t;

  // One result word
  typedef struct packed {
    logic [3:0]  press_count;
    logic        warning_led;
    logic        running;
    logic        speed_valid;
    logic [15:0] speed_centi;
    logic [15:0] elapsed_report;
    logic        timed_out;
    logic        stray_stop;
  } dstt_result_t;

  // Debouncer advance for one tick
  function automatic deb_t deb_step(input logic raw, input deb_t cur, input logic [7:0] limit);
    deb_t nxt;
    nxt = cur;
    if (raw != cur.last_raw) begin
      nxt.ticks = 8'd0;
    end else if (cur.ticks != 8'hFF) begin
      nxt.ticks = cur.ticks + 8'd1;
    end
    if ((nxt.ticks > limit) && (raw != cur.stable)) begin
      nxt.stable = raw;
    end
    nxt.last_raw = raw;
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== design/dstt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dstt_ctrl
// Button debouncers and run state; forms the result of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dstt_ctrl
  import dstt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         tick,       // commit strobe: one accepted word
  input  wire logic         raw_start,
  input  wire logic         raw_stop,
  input  wire dstt_cfg_t    cfg,
  output dstt_result_t      result,     // valid alongside tick
  output logic              div_req     // speed needs a division
);

  deb_t        start_deb, start_deb_next;
  deb_t        stop_deb, stop_deb_next;
  logic        active, active_next;
  logic [15:0] elapsed, elapsed_next;
  logic [3:0]  presses, presses_next;
  logic        warning, warning_next;
  logic        start_press, stop_press;

  // Next state and result of this tick
  always_comb begin
    elapsed_next = elapsed;
    if (active && (elapsed != 16'hFFFF)) begin
      elapsed_next = elapsed + 16'd1;
    end
    start_deb_next = deb_step(raw_start, start_deb, cfg.debounce_ms);
    stop_deb_next  = deb_step(raw_stop, stop_deb, cfg.debounce_ms);
    start_press = (start_deb_next.stable != start_deb.stable) && !start_deb_next.stable;
    stop_press  = (stop_deb_next.stable != stop_deb.stable) && !stop_deb_next.stable;

    active_next  = active;
    presses_next = presses;
    warning_next = warning;
    result       = '0;
    div_req      = 1'b0;

    // start button
    if (start_press) begin
      warning_next = 1'b0;
      presses_next = presses + 4'd1;
      if (!active) begin
        elapsed_next = 16'd0;
        active_next  = 1'b1;
      end
    end

    // timeout
    if (active_next && (elapsed_next >= cfg.timeout_ms)) begin
      active_next           = 1'b0;
      warning_next          = 1'b1;
      result.speed_valid    = 1'b1;
      result.timed_out      = 1'b1;
      result.speed_centi    = cfg.min_speed_centi;
      result.elapsed_report = cfg.timeout_ms;
    end

    // stop button
    if (stop_press) begin
      if (active_next) begin
        active_next           = 1'b0;
        result.speed_valid    = 1'b1;
        result.elapsed_report = elapsed_next;
        if (elapsed_next == 16'd0) begin
          result.speed_centi = cfg.max_speed_centi;
        end else begin
          result.speed_centi = 16'd0;
          div_req            = 1'b1;
        end
      end else begin
        warning_next      = 1'b1;
        result.stray_stop = 1'b1;
      end
    end

    result.press_count = presses_next;
    result.warning_led = warning_next;
    result.running     = active_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_deb <= '{last_raw: 1'b1, stable: 1'b1, ticks: 8'hFF};
      stop_deb  <= '{last_raw: 1'b1, stable: 1'b1, ticks: 8'hFF};
      active    <= 1'b0;
      elapsed   <= 16'd0;
      presses   <= 4'd0;
      warning   <= 1'b0;
    end else if (tick) begin
      start_deb <= start_deb_next;
      stop_deb  <= stop_deb_next;
      active    <= active_next;
      elapsed   <= elapsed_next;
      presses   <= presses_next;
      warning   <= warning_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/dstt_div.sv =====
// ----------------------------------------------------------------------------
// dstt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dstt_div
  import dstt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,      // one-cycle pulse, quotient ready
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [STEP_CNT_W-1:0] cnt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Trial subtract
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - STEP_CNT_W'(1);
        if (cnt == STEP_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      rem      <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/debounced_speed_trap_timer.sv =====
// ----------------------------------------------------------------------------
// debounced_speed_trap_timer
// Two-button speed timer with debounce; one result word per tick word.
// ----------------------------------------------------------------------------
//  channel   | signals                           | carries
//  s_*       | tvalid tready tdata[7:0]          | one millisecond tick
//  m_*       | tvalid tready tdata[39:0] tuser   | one result per tick
//  cfg_*     | valid ready index[2:0] data[15:0] | register write
//
//  A tick goes from idle to the emit step, by way of the divide step when a stop
//  press needs the speed worked out: the divider retires one quotient bit per
//  cycle over 21 bits. s_tready is high only while the sequencer is idle.
//  A finished word waits in the output register; a stalled m_tready holds the
//  sequencer before its emit step. Reset is synchronous and restores the
//  default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_speed_trap_timer
  import dstt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] raw_start, [1] raw_stop
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] press_count, [4] warning_led, [5] running, [21:6] speed_centi,
  // [37:22] elapsed_report
  output logic [39:0]      m_tdata,
  output logic [2:0]       m_tuser,   // [0] speed_valid, [1] timed_out, [2] stray_stop
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                  state, state_next;
  dstt_cfg_t               cfg;
  dstt_result_t            tick_res;
  dstt_result_t            res;
  logic                    accept;
  logic                    div_req;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [DIVIDEND_W-1:0]   dividend;
  logic [DIVIDEND_W-1:0]   quotient;
  logic [15:0]             speed_capped;
  logic                    out_free;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= 8'd25;
      cfg.timeout_ms      <= 16'd10800;
      cfg.distance_mm     <= 12'd600;
      cfg.min_speed_centi <= 16'd20;
      cfg.max_speed_centi <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:  cfg.debounce_ms     <= cfg_data[7:0];
        REG_TIMEOUT:   cfg.timeout_ms      <= cfg_data;
        REG_DISTANCE:  cfg.distance_mm     <= cfg_data[11:0];
        REG_MIN_SPEED: cfg.min_speed_centi <= cfg_data;
        REG_MAX_SPEED: cfg.max_speed_centi <= cfg_data;
        default: ;
      endcase
    end
  end

  dstt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tick      (accept),
    .raw_start (s_tdata[0]),
    .raw_stop  (s_tdata[1]),
    .cfg       (cfg),
    .result    (tick_res),
    .div_req   (div_req)
  );

  // distance * 360 = distance * (256 + 64 + 32 + 8)
  always_comb begin
    dividend = (DIVIDEND_W'(cfg.distance_mm) << 8) + (DIVIDEND_W'(cfg.distance_mm) << 6)
             + (DIVIDEND_W'(cfg.distance_mm) << 5) + (DIVIDEND_W'(cfg.distance_mm) << 3);
  end

  assign div_start = accept && div_req;

  dstt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (tick_res.elapsed_report),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Cap at the maximum speed
  assign speed_capped = (quotient > DIVIDEND_W'(cfg.max_speed_centi)) ?
                        cfg.max_speed_centi : quotient[15:0];

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = div_req ? ST_DIV : ST_EMIT;
      ST_DIV:  if (div_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pending result word
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= tick_res;
    end else if ((state == ST_DIV) && div_done) begin
      res.speed_centi <= speed_capped;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {2'b00, res.elapsed_report, res.speed_centi, res.running,
                  res.warning_led, res.press_count};
      m_tuser <= {res.stray_stop, res.timed_out, res.speed_valid};
    end
  end

  // Checks
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("input ready while divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[37:6] == 32'd0))
    else $error("speed fields set without a report");

  a_speed_capped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] && !m_tuser[1]) |-> (m_tdata[21:6] <= cfg.max_speed_centi))
    else $error("measured speed above the cap");

endmodule

`default_nettype wire
